FILE: src/magic_length_packet_deframer_top_defines.svh
// Assertion macros shared by the deframer modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef MAGIC_LENGTH_PACKET_DEFRAMER_TOP_DEFINES_SVH
`define MAGIC_LENGTH_PACKET_DEFRAMER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge outside reset
`define MLPD_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("mlpd: assertion failed");

// Check that a trigger implies a condition in the same cycle
`define MLPD_ASSERT_IMPL(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("mlpd: implication failed");

`else

`define MLPD_ASSERT(lbl, cond)
`define MLPD_ASSERT_IMPL(lbl, trig, cond)

`endif

`endif

FILE: src/mlpd_pkg.sv
`timescale 1ns / 1ps

package mlpd_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_HEADER    = 2'd0,
        KIND_PAYLOAD   = 2'd1,
        KIND_BAD_MAGIC = 2'd2
    } t_kind;

    localparam int          WORD_BYTES    = 28;
    localparam int          POS_W         = 6;
    localparam logic [31:0] MAGIC_DEFAULT = 32'hDEADBEEF;
    localparam int          FIFO_DEPTH    = 2;
    localparam int          FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int          FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    // Classified item passed from the front to the back
    typedef struct packed {
        logic [7:0]       data;
        logic [POS_W-1:0] hpos;
        logic             capture;
        logic             emit;
        t_kind            kind;
        logic             last;
    } t_cmd;

endpackage

FILE: src/mlpd_front.sv
`timescale 1ns / 1ps

module mlpd_front #(
    parameter int HEADER_BYTES = 44
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [7:0]   i_data,
    input  logic         i_cfg_valid,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_full,
    output logic         o_push,
    output mlpd_pkg::t_cmd o_cmd
);
    import mlpd_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] LEN_POS  = POS_W'(16);
    localparam logic [POS_W-1:0] CAP_LO   = POS_W'(4);
    localparam logic [POS_W-1:0] CAP_HI   = POS_W'(WORD_BYTES);

    logic [31:0]      r_expected;
    logic             r_in_payload, n_in_payload;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_left, n_left;
    logic [31:0]      r_magic, n_magic;
    logic [31:0]      r_len, n_len;
    logic             accept;
    logic             hdr_mode;
    logic [POS_W-1:0] pos;
    logic             bad;
    t_cmd             cmd;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;
    assign o_cmd   = cmd;

    // Classify the byte and work out the next state
    always_comb begin
        hdr_mode     = !r_in_payload || (r_left == 32'd0);
        pos          = r_in_payload ? '0 : r_pos;
        n_magic      = r_magic;
        n_len        = r_len;
        n_in_payload = r_in_payload;
        n_pos        = r_pos;
        n_left       = r_left;
        bad          = 1'b0;
        cmd.data     = i_data;
        cmd.hpos     = pos;
        cmd.capture  = 1'b0;
        cmd.emit     = 1'b0;
        cmd.kind     = KIND_PAYLOAD;
        cmd.last     = 1'b0;
        if (hdr_mode) begin
            // collect the magic and length words locally
            if (pos < CAP_LO) begin
                n_magic[pos[1:0]*8 +: 8] = i_data;
            end
            if (pos >= LEN_POS && pos < LEN_POS + POS_W'(4)) begin
                n_len[pos[1:0]*8 +: 8] = i_data;
            end
            cmd.capture = (pos >= CAP_LO) && (pos < CAP_HI);
            if (pos == LAST_POS) begin
                bad          = (n_magic != r_expected);
                cmd.emit     = 1'b1;
                cmd.kind     = bad ? KIND_BAD_MAGIC : KIND_HEADER;
                cmd.last     = bad || (n_len == 32'd0);
                n_pos        = '0;
                n_in_payload = !bad && (n_len != 32'd0);
                n_left       = n_len;
            end else begin
                n_pos        = pos + POS_W'(1);
                n_in_payload = 1'b0;
            end
        end else begin
            // pass a payload byte and count it down
            cmd.emit = 1'b1;
            cmd.kind = KIND_PAYLOAD;
            cmd.last = (r_left == 32'd1);
            n_left   = r_left - 32'd1;
            if (r_left == 32'd1) begin
                n_in_payload = 1'b0;
                n_pos        = '0;
            end
        end
    end

    // Hold the magic register and framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected   <= MAGIC_DEFAULT;
            r_in_payload <= 1'b0;
            r_pos        <= '0;
            r_left       <= '0;
            r_magic      <= '0;
            r_len        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_expected <= i_cfg_data;
            end
            if (accept) begin
                r_in_payload <= n_in_payload;
                r_pos        <= n_pos;
                r_left       <= n_left;
                r_magic      <= n_magic;
                r_len        <= n_len;
            end
        end
    end

endmodule

FILE: src/mlpd_fifo.sv
`timescale 1ns / 1ps

`include "magic_length_packet_deframer_top_defines.svh"

module mlpd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mlpd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output mlpd_pkg::t_cmd o_cmd
);
    import mlpd_pkg::*;

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wptr;
    logic [FIFO_PTR_W-1:0] r_rptr;
    logic [FIFO_CNT_W-1:0] r_count;

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

    // Store items at the write pointer
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Advance pointers and track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                  : r_wptr + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                  : r_rptr + FIFO_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + FIFO_CNT_W'(1);
                2'b01:   r_count <= r_count - FIFO_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `MLPD_ASSERT(a_count_bound, r_count <= FIFO_CNT_W'(FIFO_DEPTH))
    `MLPD_ASSERT_IMPL(a_no_overflow, i_push, !o_full || i_pop)
    `MLPD_ASSERT_IMPL(a_no_underflow, i_pop, !o_empty)

endmodule

FILE: src/mlpd_back.sv
`timescale 1ns / 1ps

`include "magic_length_packet_deframer_top_defines.svh"

module mlpd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  mlpd_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_kind,
    output logic [191:0]   o_words,
    output logic [7:0]     o_byte,
    output logic           o_last
);
    import mlpd_pkg::*;

    logic [31:0]  r_words [1:6];
    logic [31:0]  n_words [1:6];
    logic         r_valid;
    t_kind        r_kind;
    logic [191:0] r_out_words;
    logic [7:0]   r_byte;
    logic         r_last;
    logic [2:0]   widx;

    assign widx  = i_cmd.hpos[4:2];
    assign o_pop = !i_empty && (!i_cmd.emit || !r_valid || i_ready);

    // Merge the incoming header byte into the captured words
    always_comb begin
        for (int w = 1; w <= 6; w++) begin
            n_words[w] = r_words[w];
            if (i_cmd.capture && (widx == 3'(w))) begin
                n_words[w][i_cmd.hpos[1:0]*8 +: 8] = i_cmd.data;
            end
        end
    end

    // Hold captured header words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 1; w <= 6; w++) begin
                r_words[w] <= '0;
            end
        end else if (o_pop && i_cmd.capture) begin
            for (int w = 1; w <= 6; w++) begin
                r_words[w] <= n_words[w];
            end
        end
    end

    // Load the output register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop && i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.emit) begin
            r_kind      <= i_cmd.kind;
            r_out_words <= {n_words[6], n_words[5], n_words[4],
                            n_words[3], n_words[2], n_words[1]};
            r_byte      <= (i_cmd.kind == KIND_PAYLOAD) ? i_cmd.data : 8'd0;
            r_last      <= i_cmd.last;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_words = r_out_words;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    `MLPD_ASSERT_IMPL(a_bad_magic_ends, r_valid && (r_kind == KIND_BAD_MAGIC),
        r_last && (r_byte == 8'd0))
    `MLPD_ASSERT_IMPL(a_header_last_len, r_valid && (r_kind == KIND_HEADER),
        r_last == (r_out_words[127:96] == 32'd0))
    `MLPD_ASSERT_IMPL(a_capture_range, !i_empty && i_cmd.capture,
        (widx != 3'd0) && (widx != 3'd7))

endmodule

FILE: src/magic_length_packet_deframer_top.sv
`timescale 1ns / 1ps

// Length-prefixed packet deframer. Takes one received byte per item on the
// slave stream and sustains one item per clock while its queue is not full.
// A header of HEADER_BYTES bytes (seven little-endian words: magic, protocol,
// sequence, message type, payload length, source address, source port, then
// reserved bytes) gives no result until its final byte, which yields a header
// result (tuser 0) or, if the magic word differs from the value on the
// configuration port (reset 0xDEADBEEF), a bad-magic result (tuser 2, tlast 1)
// after which header collection restarts. Each payload byte then gives one
// result (tuser 1), the final one with tlast. Every result carries the current
// header words. A result passes from the classifying front stage through its
// two-entry queue to the output register of the back stage; the queue lets the
// input keep flowing while a result waits to be taken.
module magic_length_packet_deframer_top #(
    parameter int HEADER_BYTES = 44
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // rx_byte
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // proto_word, seq_word, msg_word, payload_len, src_addr, src_port, payload_byte
    output logic [199:0] o_m_axis_tdata,
    output logic [1:0]   o_m_axis_tuser,   // result_kind
    output logic         o_m_axis_tlast,   // last
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data        // expected_magic
);
    import mlpd_pkg::*;

    t_cmd         front_cmd;
    t_cmd         queue_cmd;
    logic         push;
    logic         pop;
    logic         full;
    logic         empty;
    logic [191:0] words;
    logic [7:0]   pbyte;

    assign o_cfg_ready = 1'b1;

    mlpd_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    mlpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    mlpd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_kind  (o_m_axis_tuser),
        .o_words (words),
        .o_byte  (pbyte),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {pbyte, words};

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mlpd_pkg::*;

    localparam int HDR_BYTES   = 44;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 300;

    // One expected output item of the deframer
    typedef struct packed {
        t_kind       kind;
        logic [31:0] proto;
        logic [31:0] seq;
        logic [31:0] msg;
        logic [31:0] len;
        logic [31:0] addr;
        logic [31:0] port;
        logic [7:0]  pbyte;
        logic        last;
    } t_frame_item;

    // Tracks deframer state and the frame items still owed by the block
    class frame_tracker;
        logic [31:0]  magic;
        logic [5:0]   hdr_pos;
        logic [31:0]  words [7];
        logic [31:0]  left;
        bit           in_payload;
        t_frame_item  items_due [$];
        int           n_fail;
        int           n_bytes;
        int           n_header;
        int           n_payload;
        int           n_bad;

        function new();
            magic      = MAGIC_DEFAULT;
            hdr_pos    = '0;
            left       = '0;
            in_payload = 0;
            foreach (words[i]) words[i] = '0;
        endfunction

        function int depth();
            return items_due.size();
        endfunction

        function void set_magic(logic [31:0] m);
            magic = m;
        endfunction

        function void push(t_kind k, logic [7:0] b, logic l);
            t_frame_item it;
            it.kind  = k;
            it.proto = words[1];
            it.seq   = words[2];
            it.msg   = words[3];
            it.len   = words[4];
            it.addr  = words[5];
            it.port  = words[6];
            it.pbyte = b;
            it.last  = l;
            items_due.push_back(it);
        endfunction

        // Advance the deframer by one accepted byte
        function void note_byte(logic [7:0] b);
            int p;
            n_bytes++;
            // drop back to the header if payload state has nothing left
            if (in_payload && left == 0) begin
                in_payload = 0;
                hdr_pos    = '0;
            end
            if (in_payload) begin
                left = left - 1;
                push(KIND_PAYLOAD, b, left == 0);
                if (left == 0) begin
                    in_payload = 0;
                    hdr_pos    = '0;
                end
                return;
            end
            p = hdr_pos;
            if (p < WORD_BYTES)
                words[p / 4][8 * (p % 4) +: 8] = b;
            if (p + 1 < HDR_BYTES) begin
                hdr_pos = p + 1;
                return;
            end
            // header complete: check magic, then length
            hdr_pos = '0;
            if (words[0] != magic) begin
                push(KIND_BAD_MAGIC, 8'h00, 1'b1);
                return;
            end
            left = words[4];
            if (left == 0) begin
                push(KIND_HEADER, 8'h00, 1'b1);
                return;
            end
            in_payload = 1;
            push(KIND_HEADER, 8'h00, 1'b0);
        endfunction

        function void cmp(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $error("%s mismatch: expected %h, actual %h", name, e, a);
                n_fail++;
            end
        endfunction

        // Compare one output item against the oldest expectation
        function void check_item(logic [1:0] kind, logic [199:0] d, logic last);
            t_frame_item e;
            if (items_due.size() == 0) begin
                $error("unexpected output item: kind %0d, last %0d", kind, last);
                n_fail++;
                return;
            end
            e = items_due.pop_front();
            cmp("result_kind", e.kind, kind);
            cmp("proto_word", e.proto, d[31:0]);
            cmp("seq_word", e.seq, d[63:32]);
            cmp("msg_word", e.msg, d[95:64]);
            cmp("payload_len", e.len, d[127:96]);
            cmp("src_addr", e.addr, d[159:128]);
            cmp("src_port", e.port, d[191:160]);
            cmp("payload_byte", e.pbyte, d[199:192]);
            cmp("last", e.last, last);
            case (e.kind)
                KIND_HEADER:    n_header++;
                KIND_PAYLOAD:   n_payload++;
                KIND_BAD_MAGIC: n_bad++;
                default: ;
            endcase
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [199:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;

    frame_tracker sb = new();
    bit           calm;
    bit           hold_req;
    int           cycles;
    int           n_cfg;

    magic_length_packet_deframer_top #(
        .HEADER_BYTES(HDR_BYTES)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Stop a hung run
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("== FAIL ==");
        $finish;
    end

    // Drive the output ready: random stalls, calm stretches, one long hold-off
    initial begin
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                m_tready = 1'b0;
                repeat (400) @(negedge i_clk);
            end
            m_tready = calm ? 1'b1 : ($urandom_range(0, 99) >= 22);
        end
    end

    // Check every accepted output item
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_item(m_tuser, m_tdata, m_tlast);
    end

    // Offer one byte, with random gaps, and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        if (!calm) begin
            while ($urandom_range(0, 99) < 22) begin
                s_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge i_clk); while (!s_tready);
        sb.note_byte(b);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.depth() != 0) @(posedge i_clk);
    endtask

    // Write the magic register once the block has gone quiet
    task automatic write_magic(input logic [31:0] m);
        stop_sending();
        wait_drained();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data  = m;
        do @(posedge i_clk); while (!cfg_ready);
        sb.set_magic(m);
        n_cfg++;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Send a header with the given words, 16 reserved bytes, then the payload
    task automatic send_packet(input logic [31:0] m, input logic [31:0] proto,
                               input logic [31:0] seq, input logic [31:0] msg,
                               input logic [31:0] len, input logic [31:0] addr,
                               input logic [31:0] port, input int n_pay);
        logic [31:0] w [7];
        w[0] = m;
        w[1] = proto;
        w[2] = seq;
        w[3] = msg;
        w[4] = len;
        w[5] = addr;
        w[6] = port;
        for (int i = 0; i < WORD_BYTES; i++)
            send_byte(w[i / 4][8 * (i % 4) +: 8]);
        repeat (HDR_BYTES - WORD_BYTES) send_byte($urandom_range(0, 255));
        repeat (n_pay) send_byte($urandom_range(0, 255));
    endtask

    // Mostly well-formed frames, some with bad magic, some raw noise
    task automatic random_packet();
        int          sel;
        logic [31:0] len;
        logic [31:0] m;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            // noise, then pad until the block is back at a header boundary
            repeat ($urandom_range(1, 60)) send_byte($urandom_range(0, 255));
            while (sb.hdr_pos != 0) send_byte($urandom_range(0, 255));
        end else if (sel < 28) begin
            if ($urandom_range(0, 1))
                m = sb.magic ^ (32'h1 << $urandom_range(0, 31));
            else
                m = sb.magic ^ ($urandom | 32'h1);
            send_packet(m, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, 0);
        end else begin
            sel = $urandom_range(0, 99);
            if (sel < 15)
                len = 0;
            else if (sel < 88)
                len = $urandom_range(1, 32);
            else
                len = $urandom_range(33, 200);
            send_packet(sb.magic, $urandom, $urandom, $urandom, len, $urandom,
                        $urandom, len);
        end
    endtask

    task automatic random_phase(input bit long_hold, input bit mid_pause);
        int start;
        int n_pkt;
        start = sb.n_bytes;
        n_pkt = 0;
        if (long_hold) begin
            // receiver stalls while a long frame keeps coming
            hold_req = 1;
            send_packet(sb.magic, $urandom, $urandom, $urandom, 120, $urandom,
                        $urandom, 120);
        end
        while (sb.n_bytes - start < PHASE_BYTES) begin
            calm = (n_pkt >= 3 && n_pkt < 6);
            random_packet();
            n_pkt++;
            if (mid_pause && n_pkt == 4) begin
                stop_sending();
                wait_drained();
            end
        end
        calm = 0;
    endtask

    initial begin
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        calm      = 0;
        hold_req  = 0;
        n_cfg     = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed frames under the reset magic
        send_packet(MAGIC_DEFAULT, '1, '1, '1, 32'd0, '1, '1, 0);
        send_packet(MAGIC_DEFAULT, '0, '0, '0, 32'd1, '0, '0, 1);
        send_packet(MAGIC_DEFAULT, 32'h5555_AAAA, 32'h1, 32'h8000_0000, 32'd2,
                    32'hFFFF_0000, 32'h0000_FFFF, 2);
        send_packet(MAGIC_DEFAULT ^ 32'h8000_0000, '0, '0, '0, '1, '0, '0, 0);
        send_packet(32'h0, '1, '1, '1, 32'h7FFF_FFFF, '1, '1, 0);
        random_phase(0, 0);

        write_magic(32'h0000_0000);
        random_phase(1, 0);
        write_magic(32'hFFFF_FFFF);
        random_phase(0, 1);
        write_magic($urandom);
        random_phase(0, 0);
        write_magic(MAGIC_DEFAULT);
        random_phase(0, 0);

        // a frame with the largest length, left running
        send_packet(sb.magic, $urandom, $urandom, $urandom, '1, $urandom,
                    $urandom, 30);
        stop_sending();
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d bytes under %0d written magic values plus the reset one",
                 sb.n_bytes, n_cfg);
        $display("Checked %0d headers, %0d bad-magic headers, %0d payload bytes",
                 sb.n_header, sb.n_bad, sb.n_payload);
        if (sb.n_fail == 0 && sb.depth() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
